>>> hdl/sso_pkg.sv
// shared constants, register codes and the sine table generator for the
// servo sine oscillator with slew limiting; no dependencies
package sso_pkg;

    // timing and table sizing
    localparam int unsigned SAMPLE_PERIOD_MS = 30;
    localparam int unsigned SINE_TABLE_DEPTH = 256;

    // item kinds on tuser
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_DIRECT = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_PHASE_STEP    = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE     = 3'd1;
    localparam logic [2:0] REG_CENTER_OFFSET = 3'd2;
    localparam logic [2:0] REG_PHASE_START   = 3'd3;
    localparam logic [2:0] REG_REVERSE       = 3'd4;
    localparam logic [2:0] REG_HALTED        = 3'd5;
    localparam logic [2:0] REG_RATE_LIMIT    = 3'd6;
    localparam logic [2:0] REG_TRIM          = 3'd7;

    // register reset values
    localparam logic [14:0] PHASE_STEP_RST = 15'd983;
    localparam logic [6:0]  AMPLITUDE_RST  = 7'd45;

    // angle constants
    localparam logic signed [10:0] ANGLE_CENTER = 11'sd90;
    localparam logic signed [10:0] ANGLE_MAX    = 11'sd180;
    localparam logic signed [9:0]  ANGLE_RST    = 10'sd90;

    // step = elapsed * rate / 1000, done as a reciprocal multiply; product is
    // capped first so the quotient fits 10 bits and stays exact
    localparam logic [19:0] SLEW_PROD_CAP = 20'd1023999;
    localparam logic [30:0] RECIP_1000    = 31'd1099511628;
    localparam int unsigned RECIP_SHIFT   = 40;

    // series constants in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // one sine table entry in Q1.15 from quadrant and in-quadrant angle x (Q30)
    function automatic logic signed [15:0] sine_q15(input logic [1:0] quad,
                                                    input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        pt;
        logic signed [63:0] acc;
        logic [63:0]        mag;
        x2  = (x * x) >> 30;
        t   = quad[0] ? ONE_Q30 : x;
        acc = 64'sd0;
        for (int k = 0; k < 7; k++)
        begin
            if (k % 2 == 1)
                acc = acc - $signed(t);
            else
                acc = acc + $signed(t);
            pt = (t * x2) >> 30;
            if (quad[0])
            begin
                case (k)
                    0: t = pt / 2;
                    1: t = pt / 12;
                    2: t = pt / 30;
                    3: t = pt / 56;
                    4: t = pt / 90;
                    5: t = pt / 132;
                    default: t = pt / 182;
                endcase
            end
            else
            begin
                case (k)
                    0: t = pt / 6;
                    1: t = pt / 20;
                    2: t = pt / 42;
                    3: t = pt / 72;
                    4: t = pt / 110;
                    5: t = pt / 156;
                    default: t = pt / 210;
                endcase
            end
        end
        if (acc < 0)
            acc = 64'sd0;
        if (acc > $signed(ONE_Q30))
            acc = $signed(ONE_Q30);
        mag = ($unsigned(acc) * 64'd32767 + 64'd536870912) >> 30;
        return quad[1] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
    endfunction

endpackage

>>> hdl/servo_sine_oscillator_slew.sv
// servo angle generator: phase accumulator sine oscillator, slew limiter,
// trim and clamp in a five-stage pipeline; depends on sso_pkg
// an item passes from the input register through stages 1 to 5 into the output
// register; ticks that are not due, or due while halted, give no result
// throughput: one item per cycle; a result held at the output stalls the pipeline
// reset: asynchronous active low; registers to defaults, phase 0, angle 90
module servo_sine_oscillator_slew
    import sso_pkg::*;
#(
    parameter int unsigned SINE_DEPTH = SINE_TABLE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // now_ms [31:0], position [41:32], zero [47:42]
    input  logic        s_tuser,   // operation
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // servo_angle [7:0]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned IDX_W  = $clog2(SINE_DEPTH);
    localparam int unsigned MULT_W = 16 + $clog2(SINE_DEPTH + 1);

    // configuration registers
    logic [14:0]       phase_step_reg;
    logic [6:0]        amplitude_reg;
    logic signed [7:0] center_offset_reg;
    logic [15:0]       phase_start_reg;
    logic              reverse_reg;
    logic              halted_reg;
    logic [9:0]        rate_limit_reg;
    logic signed [7:0] trim_reg;

    // state
    logic [15:0]       phase_reg;
    logic [31:0]       last_sample_reg;
    logic [31:0]       last_cmd_reg;
    logic signed [9:0] angle_reg;

    // pipeline
    logic              adv;
    logic              in_valid_reg;
    logic              in_op_reg;
    logic [31:0]       in_now_reg;
    logic signed [9:0] in_pos_reg;

    logic              p1_valid_reg;
    logic              p1_direct_reg;
    logic [31:0]       p1_now_reg;
    logic signed [9:0] p1_pos_reg;
    logic [IDX_W-1:0]  p1_idx_reg;

    logic               p2_valid_reg;
    logic               p2_direct_reg;
    logic [31:0]        p2_now_reg;
    logic signed [9:0]  p2_pos_reg;
    logic signed [23:0] p2_prod_reg;

    logic              p3_valid_reg;
    logic signed [9:0] p3_target_reg;
    logic [25:0]       p3_slew_reg;

    logic              p4_valid_reg;
    logic signed [9:0] p4_target_reg;
    logic [9:0]        p4_step_reg;

    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;

    // sine table, built at elaboration
    logic signed [15:0] sine_lut [SINE_DEPTH];

    for (genvar g = 0; g < SINE_DEPTH; g++)
    begin : g_sine
        localparam logic [63:0] N4   = 64'(g) * 64'd4;
        localparam logic [63:0] QUAD = (N4 / SINE_DEPTH) % 4;
        localparam logic [63:0] R    = N4 % SINE_DEPTH;
        localparam logic [63:0] X    = R * HALF_PI_Q30 / SINE_DEPTH;
        assign sine_lut[g] = sine_q15(QUAD[1:0], X);
    end

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= PHASE_STEP_RST;
            amplitude_reg     <= AMPLITUDE_RST;
            center_offset_reg <= '0;
            phase_start_reg   <= '0;
            reverse_reg       <= 1'b0;
            halted_reg        <= 1'b0;
            rate_limit_reg    <= '0;
            trim_reg          <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PHASE_STEP:    phase_step_reg    <= cfg_data[14:0];
                REG_AMPLITUDE:     amplitude_reg     <= cfg_data[6:0];
                REG_CENTER_OFFSET: center_offset_reg <= $signed(cfg_data[7:0]);
                REG_PHASE_START:   phase_start_reg   <= cfg_data;
                REG_REVERSE:       reverse_reg       <= cfg_data[0];
                REG_HALTED:        halted_reg        <= cfg_data[0];
                REG_RATE_LIMIT:    rate_limit_reg    <= cfg_data[9:0];
                REG_TRIM:          trim_reg          <= $signed(cfg_data[7:0]);
                default: ;
            endcase
        end
    end

    // stage 1: period check, phase advance, table index
    logic [31:0]       since_sample;
    logic              due;
    logic [15:0]       phase_sum;
    logic [MULT_W-1:0] idx_prod;
    logic [IDX_W-1:0]  idx_next;

    always_comb
    begin
        since_sample = in_now_reg - last_sample_reg;
        due          = since_sample > 32'(SAMPLE_PERIOD_MS);
        phase_sum    = phase_reg + phase_start_reg;
        idx_prod     = MULT_W'(phase_sum) * MULT_W'(SINE_DEPTH);
        idx_next     = idx_prod[16 +: IDX_W];
    end

    // stage 3: rounding, offset, direction, centering; slew product
    logic [22:0]        prod_abs;
    logic [22:0]        prod_rnd;
    logic signed [10:0] osc_val;
    logic signed [10:0] osc_target;
    logic signed [9:0]  target_next;
    logic [31:0]        elapsed;
    logic [15:0]        elapsed_sat;

    always_comb
    begin
        prod_abs = p2_prod_reg[23] ? 23'(-p2_prod_reg) : p2_prod_reg[22:0];
        prod_rnd = (prod_abs + 23'd16384) >> 15;
        osc_val  = p2_prod_reg[23] ? -$signed({3'b000, prod_rnd[7:0]})
                                   : $signed({3'b000, prod_rnd[7:0]});
        osc_val  = osc_val + 11'(center_offset_reg);
        if (reverse_reg)
            osc_val = -osc_val;
        osc_target  = osc_val + ANGLE_CENTER;
        target_next = p2_direct_reg ? p2_pos_reg : osc_target[9:0];
        elapsed     = p2_now_reg - last_cmd_reg;
        elapsed_sat = (|elapsed[31:16]) ? 16'hFFFF : elapsed[15:0];
    end

    // stage 4: step = max(1, min(product, SLEW_PROD_CAP) / 1000)
    logic [19:0] slew_cap;
    logic [50:0] recip_prod;
    logic [9:0]  quot;

    always_comb
    begin
        slew_cap   = (p3_slew_reg > 26'(SLEW_PROD_CAP)) ? SLEW_PROD_CAP : p3_slew_reg[19:0];
        recip_prod = 51'(slew_cap) * 51'(RECIP_1000);
        quot       = recip_prod[RECIP_SHIFT +: 10];
    end

    // stage 5: slew toward target, trim, clamp
    logic signed [10:0] diff;
    logic [10:0]        diff_abs;
    logic signed [10:0] moved;
    logic signed [9:0]  angle_next;
    logic signed [10:0] trimmed;
    logic [7:0]         angle_out;

    always_comb
    begin
        diff     = 11'(p4_target_reg) - 11'(angle_reg);
        diff_abs = diff[10] ? 11'(-diff) : diff;
        moved    = diff[10] ? 11'(angle_reg) - $signed({1'b0, p4_step_reg})
                            : 11'(angle_reg) + $signed({1'b0, p4_step_reg});
        if ((rate_limit_reg != '0) && (diff_abs > {1'b0, p4_step_reg}))
            angle_next = moved[9:0];
        else
            angle_next = p4_target_reg;
        trimmed = 11'(angle_next) + 11'(trim_reg);
        if (trimmed < 0)
            angle_out = 8'd0;
        else if (trimmed > ANGLE_MAX)
            angle_out = 8'(ANGLE_MAX);
        else
            angle_out = trimmed[7:0];
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            p3_valid_reg    <= 1'b0;
            p4_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            phase_reg       <= '0;
            last_sample_reg <= '0;
            last_cmd_reg    <= '0;
            angle_reg       <= ANGLE_RST;
        end
        else if (adv)
        begin
            in_valid_reg <= s_tvalid;
            // only items that write a target go past stage 1
            p1_valid_reg <= in_valid_reg &&
                            ((in_op_reg == OP_DIRECT) || (due && !halted_reg));
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            m_tvalid_reg <= p4_valid_reg;
            if (in_valid_reg && (in_op_reg == OP_TICK) && due)
            begin
                last_sample_reg <= in_now_reg;
                phase_reg       <= phase_reg + 16'(phase_step_reg);
            end
            if (p2_valid_reg)
                last_cmd_reg <= p2_now_reg;
            if (p4_valid_reg)
                angle_reg <= angle_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_op_reg  <= s_tuser;
            in_now_reg <= s_tdata[31:0];
            in_pos_reg <= $signed(s_tdata[41:32]);

            p1_direct_reg <= (in_op_reg == OP_DIRECT);
            p1_now_reg    <= in_now_reg;
            p1_pos_reg    <= in_pos_reg;
            p1_idx_reg    <= idx_next;

            p2_direct_reg <= p1_direct_reg;
            p2_now_reg    <= p1_now_reg;
            p2_pos_reg    <= p1_pos_reg;
            p2_prod_reg   <= $signed({1'b0, amplitude_reg}) * sine_lut[p1_idx_reg];

            p3_target_reg <= target_next;
            p3_slew_reg   <= 26'(elapsed_sat) * 26'(rate_limit_reg);

            p4_target_reg <= p3_target_reg;
            p4_step_reg   <= (quot == '0) ? 10'd1 : quot;

            m_tdata_reg <= angle_out;
        end
    end

endmodule

>>> tb/testbench.sv
// self-checking bench for servo_sine_oscillator_slew: ticks and direct position
// commands under several register settings, angles checked against an in-bench model
// depends on sso_pkg and the servo_sine_oscillator_slew rtl
`timescale 1ns / 100ps

module testbench;
    import sso_pkg::*;

    // model of the oscillator, slew limiter and clamp plus the angles still due
    class servo_angle_checker;
        logic [14:0]        phase_step;
        logic [6:0]         amplitude;
        logic signed [7:0]  center_offset;
        logic [15:0]        phase_start;
        logic               reverse;
        logic               halted;
        logic [9:0]         rate_limit;
        logic signed [7:0]  trim;

        logic [15:0]        phase;
        logic [31:0]        last_sample_ms;
        logic [31:0]        last_cmd_ms;
        int                 angle;

        logic [7:0]         angles_due[$];
        int                 errors;

        function new();
            phase_step     = PHASE_STEP_RST;
            amplitude      = AMPLITUDE_RST;
            center_offset  = '0;
            phase_start    = '0;
            reverse        = 1'b0;
            halted         = 1'b0;
            rate_limit     = '0;
            trim           = '0;
            phase          = '0;
            last_sample_ms = '0;
            last_cmd_ms    = '0;
            angle          = int'(ANGLE_RST);
            errors         = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [15:0] data);
            case (index)
                REG_PHASE_STEP:    phase_step    = data[14:0];
                REG_AMPLITUDE:     amplitude     = data[6:0];
                REG_CENTER_OFFSET: center_offset = data[7:0];
                REG_PHASE_START:   phase_start   = data[15:0];
                REG_REVERSE:       reverse       = data[0];
                REG_HALTED:        halted        = data[0];
                REG_RATE_LIMIT:    rate_limit    = data[9:0];
                REG_TRIM:          trim          = data[7:0];
                default: ;
            endcase
        endfunction

        // table entry in q1.15: quadrant fold, then taylor series in q30
        function int sine_entry(int unsigned idx);
            longint unsigned n;
            longint unsigned quad;
            longint unsigned r;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned t;
            longint unsigned d;
            longint unsigned mag;
            longint          acc;
            n    = 64'(idx) * 64'd4;
            quad = (n / SINE_TABLE_DEPTH) & 64'd3;
            r    = n % SINE_TABLE_DEPTH;
            x    = r * 64'd1686629713 / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            t    = quad[0] ? 64'd1073741824 : x;
            d    = quad[0] ? 64'd1 : 64'd2;
            acc  = 0;
            for (int k = 0; k < 7; k++)
            begin
                if (k % 2 == 1)
                    acc = acc - longint'(t);
                else
                    acc = acc + longint'(t);
                t = ((t * x2) >> 30) / (d * (d + 64'd1));
                d = d + 64'd2;
            end
            if (acc < 0)
                acc = 0;
            if (acc > 64'sd1073741824)
                acc = 64'sd1073741824;
            mag = (longint'(acc) * 32767 + 64'd536870912) >> 30;
            return quad[1] ? -int'(mag) : int'(mag);
        endfunction

        // move the angle toward target within the slew allowance, then trim and clamp
        function logic [7:0] slew_to(int target, logic [31:0] now);
            logic [31:0] elapsed;
            int          step;
            int          diff;
            int          result;
            if (rate_limit != 0)
            begin
                elapsed = now - last_cmd_ms;
                if (elapsed > 32'd65535)
                    elapsed = 32'd65535;
                step = int'(elapsed) * int'(rate_limit) / 1000;
                if (step < 1)
                    step = 1;
                diff = target - angle;
                if ((diff < 0 ? -diff : diff) > step)
                    angle = angle + ((diff < 0) ? -step : step);
                else
                    angle = target;
            end
            else
                angle = target;
            last_cmd_ms = now;
            result = angle + int'(trim);
            if (result < 0)
                result = 0;
            if (result > 180)
                result = 180;
            return result[7:0];
        endfunction

        function void note_item(logic op, logic [31:0] now, logic signed [9:0] position);
            logic [31:0] since;
            logic [15:0] p;
            int unsigned idx;
            int          prod;
            int          rnd;
            int          level;
            if (op == OP_DIRECT)
            begin
                angles_due.push_back(slew_to(int'(position), now));
                return;
            end
            since = now - last_sample_ms;
            if (since > SAMPLE_PERIOD_MS)
            begin
                last_sample_ms = now;
                if (!halted)
                begin
                    p     = phase + phase_start;
                    idx   = (int'(p) * SINE_TABLE_DEPTH) >> 16;
                    prod  = int'(amplitude) * sine_entry(idx);
                    rnd   = ((prod < 0 ? -prod : prod) + 16384) >>> 15;
                    if (prod < 0)
                        rnd = -rnd;
                    level = rnd + int'(center_offset);
                    if (reverse)
                        level = -level;
                    angles_due.push_back(slew_to(level + 90, now));
                end
                phase = phase + 16'(phase_step);
            end
        endfunction

        function void check_angle(logic [7:0] got);
            logic [7:0] want;
            if (angles_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected angle %0d", got);
                return;
            end
            want = angles_due.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("angle mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    servo_sine_oscillator_slew u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    servo_angle_checker sb;
    logic [31:0]        clock_ms;
    int                 idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_angle(m_tdata);
    end

    // result side: random stall bursts
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic cfg_write(input logic [2:0] index, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_all(input logic [15:0] step_v, input logic [15:0] amp_v,
                               input logic [15:0] ofs_v, input logic [15:0] start_v,
                               input logic [15:0] rev_v, input logic [15:0] halt_v,
                               input logic [15:0] rate_v, input logic [15:0] trim_v);
        cfg_write(REG_PHASE_STEP, step_v);
        cfg_write(REG_AMPLITUDE, amp_v);
        cfg_write(REG_CENTER_OFFSET, ofs_v);
        cfg_write(REG_PHASE_START, start_v);
        cfg_write(REG_REVERSE, rev_v);
        cfg_write(REG_HALTED, halt_v);
        cfg_write(REG_RATE_LIMIT, rate_v);
        cfg_write(REG_TRIM, trim_v);
    endtask

    task automatic send_item(input logic op, input logic [31:0] now, input logic [9:0] pos);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, pos, now};
        do @(posedge clk); while (!s_tready);
        sb.note_item(op, now, pos);
    endtask

    task automatic sender_gap(input int cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // stop sending and let every due angle drain, with margin for dropped ticks
    task automatic drain();
        sender_gap(1);
        while (sb.angles_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_item();
        int         r;
        logic [9:0] pos;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            clock_ms = clock_ms + $urandom_range(31, 120);
            send_item(OP_TICK, clock_ms, 10'($urandom_range(0, 1023)));
        end
        else if (r < 72)
        begin
            clock_ms = clock_ms + $urandom_range(0, 30);
            send_item(OP_TICK, clock_ms, 10'($urandom_range(0, 1023)));
        end
        else if (r < 75)
        begin
            clock_ms = clock_ms + $urandom;
            send_item(OP_TICK, clock_ms, 10'($urandom_range(0, 1023)));
        end
        else
        begin
            clock_ms = clock_ms + $urandom_range(0, 1500);
            if (r < 90)
                pos = 10'(int'($urandom_range(0, 540)) - 180);
            else
                pos = 10'($urandom_range(0, 1023));
            send_item(OP_DIRECT, clock_ms, pos);
        end
    endtask

    task automatic run_random(input int items, input bit hold_midway);
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 99) < idle_pct)
                sender_gap($urandom_range(1, 19));
            // sender waits for the pipeline to empty once
            if (hold_midway && i == items / 2)
            begin
                sender_gap(1);
                while (sb.angles_due.size() != 0) @(posedge clk);
            end
            random_item();
        end
        drain();
    endtask

    task automatic program_in_range(input bit raw);
        if (raw)
            program_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'h0, 16'($urandom), 16'($urandom));
        else
            program_all(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 90)),
                        16'(int'($urandom_range(0, 180)) - 90),
                        16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 1)), 16'h0, 16'($urandom_range(0, 1000)),
                        16'(int'($urandom_range(0, 180)) - 90));
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_TICK;
        cfg_valid = 1'b0;
        cfg_index = REG_PHASE_STEP;
        cfg_data  = '0;
        clock_ms  = '0;
        idle_pct  = 10;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: period boundary, field extremes, clock wrap
        send_item(OP_TICK, 32'd0, 10'd0);
        send_item(OP_TICK, 32'd30, 10'd0);
        send_item(OP_TICK, 32'd31, 10'h3FF);
        send_item(OP_TICK, 32'd62, 10'd0);
        send_item(OP_TICK, 32'd92, 10'd0);
        send_item(OP_TICK, 32'd93, 10'd0);
        send_item(OP_DIRECT, 32'd100, 10'd511);
        send_item(OP_DIRECT, 32'd110, 10'h200);
        send_item(OP_DIRECT, 32'd120, 10'd0);
        send_item(OP_DIRECT, 32'd130, 10'h3FF);
        send_item(OP_DIRECT, 32'd140, 10'd360);
        send_item(OP_DIRECT, 32'd150, 10'(-180));
        send_item(OP_TICK, 32'hFFFF_FFFF, 10'd0);
        send_item(OP_TICK, 32'h0000_0010, 10'd0);
        send_item(OP_TICK, 32'h0000_0030, 10'd0);
        send_item(OP_DIRECT, 32'hFFFF_FFFF, 10'd90);
        clock_ms = 32'hFFFF_FFFF;
        drain();

        // high slew rate limit with negative trim
        idle_pct = 20;
        program_all(16'd983, 16'd45, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 16'(-90));
        run_random(120, 1'b0);

        // upper extremes with the lowest nonzero slew rate, reversed
        idle_pct = 0;
        program_all(16'd32767, 16'd90, 16'd90, 16'd65535, 16'd1, 16'd0, 16'd1, 16'd90);
        run_random(120, 1'b1);

        // raw register bits beyond the stated ranges
        idle_pct = 30;
        program_all(16'd0, 16'd127, 16'd127, 16'd12345, 16'd0, 16'd0, 16'd1023, 16'd127);
        run_random(110, 1'b0);

        idle_pct = 10;
        program_all(16'd1, 16'd0, 16'h0080, 16'd0, 16'd1, 16'd0, 16'd0, 16'h0080);
        run_random(100, 1'b0);

        // halted: due ticks advance phase silently, direct commands still answer
        idle_pct = 15;
        program_all(16'd4096, 16'd60, 16'(-30), 16'd0, 16'd0, 16'd1, 16'd0, 16'd0);
        run_random(100, 1'b0);

        idle_pct = 25;
        program_in_range(1'b0);
        run_random(110, 1'b0);

        idle_pct = 10;
        program_in_range(1'b1);
        run_random(110, 1'b0);

        // closing stretch at full rate
        idle_pct = 0;
        program_in_range(1'b0);
        run_random(200, 1'b0);

        while (sb.angles_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
